// ----- src/ssba_pkg.sv -----
// ----------------------------------------------------------------------------
// ssba_pkg
// Shared types and codes for the swap slot bitmap allocator.
// ----------------------------------------------------------------------------
package ssba_pkg;

  localparam int SLOT_COUNT_W     = 9;
  localparam int SLOT_COUNT_RESET = 256;
  localparam int WORD_BITS        = 8;
  localparam int WORD_SHIFT       = 3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic       command;
    logic [7:0] free_slot;
  } cmd_t;

  typedef struct packed {
    logic [7:0] slot_index;
    logic [1:0] status;
  } result_t;

  // Outcome of looking at one bitmap word
  typedef struct packed {
    logic       found;
    logic [2:0] bit_idx;
    logic       last;
  } scan_t;

endpackage

// ----- src/ssba_bitmap_ram.sv -----
// ----------------------------------------------------------------------------
// ssba_bitmap_ram
// Used-bit storage, one byte per word, one write and one registered read port.
// ----------------------------------------------------------------------------
module ssba_bitmap_ram #(
  parameter int WORDS = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/ssba_word_scan.sv -----
// ----------------------------------------------------------------------------
// ssba_word_scan
// Finds the lowest free slot of one bitmap word below the slot limit.
// ----------------------------------------------------------------------------
module ssba_word_scan
  import ssba_pkg::*;
#(
  parameter int LW = 9
) (
  input  logic [7:0]    word,
  input  logic [LW-1:0] base,
  input  logic [LW-1:0] lim,
  output scan_t         scan
);

  logic [7:0]    avail;
  logic [LW-1:0] base_end;

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      avail[b] = !word[b] && ((base + LW'(b)) < lim);
    end
    base_end     = base + LW'(WORD_BITS);
    scan.found   = 1'b0;
    scan.bit_idx = 3'd0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (avail[b]) begin
        scan.found   = 1'b1;
        scan.bit_idx = 3'(b);
      end
    end
    scan.last = base_end >= lim;
  end

endmodule

// ----- src/swap_slot_bitmap_allocator.sv -----
// ----------------------------------------------------------------------------
// swap_slot_bitmap_allocator
// First-fit swap slot allocator over a used-bit bitmap kept in block RAM.
// ----------------------------------------------------------------------------
// Commands enter on in_valid/in_stall (in_data), results leave on
// out_valid/out_stall (out_data), exactly one result per command.
// cfg_write/cfg_data set slot_count; write it only while the block is idle.
// An allocate scans the bitmap one 8-bit word per cycle from slot 0 until
// it grants a free slot or passes the slot limit and reports a full map.
// A free reads the word and writes it back. Out-of-range frees and
// allocates with a zero count answer from idle, without a RAM read. The
// bitmap RAM port is the limit: one command is in work at a time.
// After reset the bitmap is cleared one word per cycle; in_stall stays high
// during that pass, configuration writes are taken throughout.
// Results sit in an output register; if it is stalled, a finished result
// is held and the next command waits until it has moved into that register.
// ----------------------------------------------------------------------------
module swap_slot_bitmap_allocator
  import ssba_pkg::*;
#(
  parameter int SLOTS = 256
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [SLOT_COUNT_W-1:0] cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  cmd_t                    in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output result_t                 out_data
);

  localparam int WORDS = (SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int LW    = ($clog2(SLOTS + 1) > SLOT_COUNT_W) ? $clog2(SLOTS + 1)
                                                            : SLOT_COUNT_W;
  localparam logic [LW-1:0] SLOTS_L = LW'(SLOTS);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE,
    S_HOLD
  } state_t;

  state_t                  state;
  logic [AW-1:0]           clr_addr;
  logic [AW-1:0]           chk_word;
  logic [7:0]              free_slot;
  result_t                 pending;
  logic [SLOT_COUNT_W-1:0] slot_count;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  logic [LW-1:0] cnt_ext;
  logic [LW-1:0] lim;
  logic [LW-1:0] base;
  logic [LW-1:0] req_ext;
  logic [AW-1:0] req_word;
  logic [AW-1:0] free_word;
  logic          req_ok;
  logic          accept;
  scan_t         scan;
  result_t       done_res;
  logic          done;
  logic          out_free;

  assign cnt_ext   = LW'(slot_count);
  assign lim       = (cnt_ext < SLOTS_L) ? cnt_ext : SLOTS_L;
  assign base      = LW'({chk_word, 3'b000});
  assign req_ext   = LW'(in_data.free_slot);
  assign req_ok    = req_ext < lim;
  assign req_word  = AW'(req_ext >> WORD_SHIFT);
  assign free_word = AW'(LW'(free_slot) >> WORD_SHIFT);
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  ssba_bitmap_ram #(
    .WORDS (WORDS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ssba_word_scan #(
    .LW (LW)
  ) u_scan (
    .word (rd_data),
    .base (base),
    .lim  (lim),
    .scan (scan)
  );

  // RAM control and the result finished this cycle, if any
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_data  = '0;
    rd_en    = 1'b0;
    rd_addr  = '0;
    done     = 1'b0;
    done_res = '0;
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
      end
      S_IDLE: begin
        if (accept) begin
          if (in_data.command == CMD_ALLOC) begin
            if (lim != '0) begin
              rd_en = 1'b1;
            end else begin
              done            = 1'b1;
              done_res.status = ST_FULL;
            end
          end else if (req_ok) begin
            rd_en   = 1'b1;
            rd_addr = req_word;
          end else begin
            done            = 1'b1;
            done_res.status = ST_RANGE;
          end
        end
      end
      S_SCAN: begin
        if (scan.found) begin
          wr_en               = 1'b1;
          wr_addr             = chk_word;
          wr_data             = rd_data | (8'b1 << scan.bit_idx);
          done                = 1'b1;
          done_res.slot_index = 8'(base | LW'(scan.bit_idx));
          done_res.status     = ST_OK;
        end else if (scan.last) begin
          done            = 1'b1;
          done_res.status = ST_FULL;
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(chk_word + 1'b1);
        end
      end
      S_FREE: begin
        wr_en               = 1'b1;
        wr_addr             = free_word;
        wr_data             = rd_data & ~(8'b1 << free_slot[2:0]);
        done                = 1'b1;
        done_res.slot_index = free_slot;
        done_res.status     = ST_OK;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      out_valid  <= 1'b0;
      slot_count <= SLOT_COUNT_W'(SLOT_COUNT_RESET);
    end else begin
      if (cfg_write) begin
        slot_count <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= AW'(clr_addr + 1'b1);
          if (clr_addr == AW'(WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            chk_word  <= '0;
            free_slot <= in_data.free_slot;
            if (!done) begin
              state <= (in_data.command == CMD_ALLOC) ? S_SCAN : S_FREE;
            end
          end
        end
        S_SCAN: begin
          if (!done) begin
            chk_word <= AW'(chk_word + 1'b1);
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data  <= pending;
            state     <= S_IDLE;
          end
        end
        default: begin
        end
      endcase
      if (done) begin
        if (out_free) begin
          out_valid <= 1'b1;
          out_data  <= done_res;
          state     <= S_IDLE;
        end else begin
          pending <= done_res;
          state   <= S_HOLD;
        end
      end
    end
  end

endmodule
